// ===== rtl/core/mhpq_pkg.sv =====
package mhpq_pkg;

    // Heap geometry
    localparam int CAPACITY     = 31;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;

    // Slot index / entry count width; slot 0 of the store is never used
    localparam int IDX_W     = $clog2(CAPACITY + 1);
    localparam int MEM_DEPTH = CAPACITY + 1;

    // Fixed port field widths
    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DECREASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INCREASE = 3'd4;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_idx   addr;
        t_entry data;
    } t_wr_req;

endpackage

// ===== rtl/core/mhpq_store.sv =====
module mhpq_store (
    input  logic             i_clk,
    input  mhpq_pkg::t_wr_req i_wr,
    input  mhpq_pkg::t_idx   i_rd_addr_a,
    input  mhpq_pkg::t_idx   i_rd_addr_b,
    output mhpq_pkg::t_entry o_rd_a,
    output mhpq_pkg::t_entry o_rd_b,
    output mhpq_pkg::t_entry o_root
);
    import mhpq_pkg::*;

    // Heap array, one write port and two registered read ports
    t_entry r_mem [MEM_DEPTH];
    t_entry r_rd_a;
    t_entry r_rd_b;
    t_entry r_root;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    // Mirror of slot 1 so the minimum is always on hand
    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.addr == t_idx'(1)) begin
            r_root <= i_wr.data;
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;
    assign o_root = r_root;

endmodule

// ===== rtl/core/min_heap_priority_queue.sv =====
// Binary min-heap priority queue with decrease-key, up to CAPACITY entries of key and
// payload held in a 1-based heap array in one synchronous RAM (two read ports, one
// write port, registered reads). A request is insert, decrease key at a slot, or
// delete minimum; every request yields exactly one result with status, the removed
// entry (delete only, else zero), the minimum after the request (zero when empty) and
// the entry count. Requests are taken one at a time: o_in_stall is high from the
// transfer until the result has been loaded into the output register, which can hold
// a result while the next request is already being worked on. Each tree level of a
// sift costs one RAM read round trip (sift-up reads the parent, sift-down reads both
// children in the same cycle), followed by the final write and the output load. No
// clearing pass is needed after reset: only slots up to the count are ever used, and
// the count resets to zero.
module min_heap_priority_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [mhpq_pkg::KIND_W-1:0]     i_in_kind,
    input  logic [mhpq_pkg::KEY_BITS-1:0]   i_in_new_key,
    input  logic [mhpq_pkg::PAYLOAD_BITS-1:0] i_in_new_payload,
    input  logic [mhpq_pkg::SLOT_W-1:0]     i_in_slot_index,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [mhpq_pkg::STATUS_W-1:0]   o_out_status,
    output logic [mhpq_pkg::KEY_BITS-1:0]   o_out_taken_key,
    output logic [mhpq_pkg::PAYLOAD_BITS-1:0] o_out_taken_payload,
    output logic [mhpq_pkg::KEY_BITS-1:0]   o_out_min_key,
    output logic [mhpq_pkg::PAYLOAD_BITS-1:0] o_out_min_payload,
    output logic [mhpq_pkg::COUNT_W-1:0]    o_out_count
);
    import mhpq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,      // wait for a request
        S_DEC_CHK,   // stored key at slot is back, check for increase
        S_SU_CMP,    // sift-up: parent is back, compare and move
        S_DEL_LAST,  // delete: last entry is back, start sift-down
        S_SD_CMP,    // sift-down: both children back, compare and move
        S_PUT,       // drop the moving entry into the hole
        S_DONE       // load the output register
    } t_state;

    t_state                  r_state, n_state;
    t_idx                    r_count, n_count;
    t_idx                    r_pos, n_pos;      // hole position during a sift
    logic [KEY_BITS-1:0]     r_key, n_key;      // moving entry
    logic [PAYLOAD_BITS-1:0] r_pay, n_pay;
    logic [STATUS_W-1:0]     r_status, n_status;
    logic [KEY_BITS-1:0]     r_taken_key, n_taken_key;
    logic [PAYLOAD_BITS-1:0] r_taken_pay, n_taken_pay;

    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_out_status;
    logic [KEY_BITS-1:0]     r_out_taken_key;
    logic [PAYLOAD_BITS-1:0] r_out_taken_pay;
    logic [KEY_BITS-1:0]     r_out_min_key;
    logic [PAYLOAD_BITS-1:0] r_out_min_pay;
    logic [COUNT_W-1:0]      r_out_count;

    // store interface
    t_wr_req wr_req;
    t_idx    rd_addr_a;
    t_idx    rd_addr_b;
    t_entry  rd_a;
    t_entry  rd_b;
    t_entry  root;

    logic             in_xfer;
    logic             out_free;
    t_idx             ins_pos;
    logic             slot_bad;
    t_idx             slot_addr;
    t_idx             su_parent;
    t_idx             dl_n;
    logic [IDX_W:0]   sd_lc, sd_rc;
    logic             sd_has_r, sd_pick_r;
    t_entry           sd_child;
    t_idx             sd_cpos;
    logic [IDX_W:0]   sd_gl, sd_gr;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign ins_pos   = r_count + t_idx'(1);
    assign slot_bad  = (i_in_slot_index == '0) || (32'(i_in_slot_index) > 32'(r_count));
    assign slot_addr = t_idx'(i_in_slot_index);
    assign su_parent = r_pos >> 1;
    assign dl_n      = r_count - t_idx'(1);

    // sift-down child selection; right child wins on equal keys
    assign sd_lc     = {r_pos, 1'b0};
    assign sd_rc     = {r_pos, 1'b1};
    assign sd_has_r  = sd_rc <= {1'b0, r_count};
    assign sd_pick_r = sd_has_r && !(rd_a.key < rd_b.key);
    assign sd_child  = sd_pick_r ? rd_b : rd_a;
    assign sd_cpos   = sd_pick_r ? sd_rc[IDX_W-1:0] : sd_lc[IDX_W-1:0];
    assign sd_gl     = {sd_cpos, 1'b0};
    assign sd_gr     = {sd_cpos, 1'b1};

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_key       = r_key;
        n_pay       = r_pay;
        n_status    = r_status;
        n_taken_key = r_taken_key;
        n_taken_pay = r_taken_pay;
        rd_addr_a   = '0;
        rd_addr_b   = '0;
        wr_req      = '0;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_key       = i_in_new_key;
                    n_pay       = i_in_new_payload;
                    n_status    = ST_OK;
                    n_taken_key = '0;
                    n_taken_pay = '0;
                    n_state     = S_DONE;
                    case (i_in_kind)
                        KIND_INSERT: begin
                            if (r_count >= t_idx'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_count = ins_pos;
                                n_pos   = ins_pos;
                                if (ins_pos == t_idx'(1)) begin
                                    n_state = S_PUT;
                                end else begin
                                    rd_addr_a = ins_pos >> 1;
                                    n_state   = S_SU_CMP;
                                end
                            end
                        end
                        KIND_DECREASE: begin
                            if (slot_bad) begin
                                n_status = ST_BAD_SLOT;
                            end else begin
                                n_pos     = slot_addr;
                                rd_addr_a = slot_addr;
                                n_state   = S_DEC_CHK;
                            end
                        end
                        KIND_DELETE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_taken_key = root.key;
                                n_taken_pay = root.payload;
                                rd_addr_a   = r_count;
                                n_state     = S_DEL_LAST;
                            end
                        end
                        default: begin
                            // unused kind: no change, status ok
                        end
                    endcase
                end
            end
            S_DEC_CHK: begin
                if (rd_a.key < r_key) begin
                    n_status = ST_INCREASE;
                    n_state  = S_DONE;
                end else begin
                    n_pay = rd_a.payload;
                    if (r_pos == t_idx'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        rd_addr_a = su_parent;
                        n_state   = S_SU_CMP;
                    end
                end
            end
            S_SU_CMP: begin
                if (r_key < rd_a.key) begin
                    // parent moves down into the hole
                    wr_req.en   = 1'b1;
                    wr_req.addr = r_pos;
                    wr_req.data = rd_a;
                    n_pos       = su_parent;
                    if (su_parent == t_idx'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        rd_addr_a = su_parent >> 1;
                    end
                end else begin
                    wr_req.en   = 1'b1;
                    wr_req.addr = r_pos;
                    wr_req.data = '{key: r_key, payload: r_pay};
                    n_state     = S_DONE;
                end
            end
            S_DEL_LAST: begin
                n_key   = rd_a.key;
                n_pay   = rd_a.payload;
                n_count = dl_n;
                n_pos   = t_idx'(1);
                if (dl_n == '0) begin
                    n_state = S_DONE;
                end else if (dl_n == t_idx'(1)) begin
                    n_state = S_PUT;
                end else begin
                    rd_addr_a = t_idx'(2);
                    rd_addr_b = (dl_n >= t_idx'(3)) ? t_idx'(3) : '0;
                    n_state   = S_SD_CMP;
                end
            end
            S_SD_CMP: begin
                wr_req.en   = 1'b1;
                wr_req.addr = r_pos;
                if (r_key <= sd_child.key) begin
                    wr_req.data = '{key: r_key, payload: r_pay};
                    n_state     = S_DONE;
                end else begin
                    // smaller child moves up into the hole
                    wr_req.data = sd_child;
                    n_pos       = sd_cpos;
                    if (sd_gl > {1'b0, r_count}) begin
                        n_state = S_PUT;
                    end else begin
                        rd_addr_a = sd_gl[IDX_W-1:0];
                        rd_addr_b = (sd_gr <= {1'b0, r_count}) ? sd_gr[IDX_W-1:0] : '0;
                    end
                end
            end
            S_PUT: begin
                wr_req.en   = 1'b1;
                wr_req.addr = r_pos;
                wr_req.data = '{key: r_key, payload: r_pay};
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            // load wins over drain; a drained register with nothing new goes empty
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_pos       <= n_pos;
        r_key       <= n_key;
        r_pay       <= n_pay;
        r_status    <= n_status;
        r_taken_key <= n_taken_key;
        r_taken_pay <= n_taken_pay;
        if (r_state == S_DONE && out_free) begin
            r_out_status    <= r_status;
            r_out_taken_key <= r_taken_key;
            r_out_taken_pay <= r_taken_pay;
            r_out_min_key   <= (r_count != '0) ? root.key : '0;
            r_out_min_pay   <= (r_count != '0) ? root.payload : '0;
            r_out_count     <= COUNT_W'(r_count);
        end
    end

    mhpq_store u_store (
        .i_clk       (i_clk),
        .i_wr        (wr_req),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_a      (rd_a),
        .o_rd_b      (rd_b),
        .o_root      (root)
    );

    assign o_out_valid         = r_out_valid;
    assign o_out_status        = r_out_status;
    assign o_out_taken_key     = r_out_taken_key;
    assign o_out_taken_payload = r_out_taken_pay;
    assign o_out_min_key       = r_out_min_key;
    assign o_out_min_payload   = r_out_min_pay;
    assign o_out_count         = r_out_count;

endmodule

// ===== rtl/core/mhpq_checker.sv =====
module mhpq_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [mhpq_pkg::STATUS_W-1:0]      o_out_status,
    input logic [mhpq_pkg::KEY_BITS-1:0]      o_out_taken_key,
    input logic [mhpq_pkg::PAYLOAD_BITS-1:0]  o_out_taken_payload,
    input logic [mhpq_pkg::KEY_BITS-1:0]      o_out_min_key,
    input logic [mhpq_pkg::PAYLOAD_BITS-1:0]  o_out_min_payload,
    input logic [mhpq_pkg::COUNT_W-1:0]       o_out_count
);
    import mhpq_pkg::*;

    // a refused request removes nothing
    a_err_no_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_status != ST_OK
        |-> o_out_taken_key == '0 && o_out_taken_payload == '0)
        else $error("taken entry on a failed request");

    // empty heap reports a zero minimum
    a_empty_min_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_count == '0
        |-> o_out_min_key == '0 && o_out_min_payload == '0)
        else $error("nonzero minimum with empty heap");

    // full only at capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_status == ST_FULL |-> o_out_count == COUNT_W'(CAPACITY))
        else $error("full status below capacity");

    // empty only with no entries
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_status == ST_EMPTY |-> o_out_count == '0)
        else $error("empty status with entries");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall
        |=> o_out_valid && $stable(o_out_status) && $stable(o_out_taken_key)
            && $stable(o_out_taken_payload) && $stable(o_out_min_key)
            && $stable(o_out_min_payload) && $stable(o_out_count))
        else $error("stalled result changed");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_out_valid         (o_out_valid),
    .i_out_stall         (i_out_stall),
    .o_out_status        (o_out_status),
    .o_out_taken_key     (o_out_taken_key),
    .o_out_taken_payload (o_out_taken_payload),
    .o_out_min_key       (o_out_min_key),
    .o_out_min_payload   (o_out_min_payload),
    .o_out_count         (o_out_count)
);
